FILE: rtl/tween_pkg.sv
// ----------------------------------------------------------------------------
// tween_pkg
// shared constants, command and status types of the tween engine
// ----------------------------------------------------------------------------
`default_nettype none

package tween_pkg;

   // progress and rate are unsigned fractions, 1.0 = 2^PROGRESS_BITS
   localparam int PROGRESS_BITS = 24;
   localparam int PW            = PROGRESS_BITS + 1;
   localparam logic [PW-1:0] PONE = {1'b1, {PROGRESS_BITS{1'b0}}};

   // divider step counter, counts 0 .. PROGRESS_BITS
   localparam int CNT_W = $clog2(PW);

   // shared multiplier: a is signed 34 bits, b is signed PROGRESS_BITS+2 bits
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = PROGRESS_BITS + 2;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // progress sum before the clamp
   localparam int SUM_W = PROGRESS_BITS + 18;

   // item kinds
   localparam logic [2:0] KIND_TICK         = 3'd0;
   localparam logic [2:0] KIND_SET_ALPHA    = 3'd1;
   localparam logic [2:0] KIND_SET_SCALE    = 3'd2;
   localparam logic [2:0] KIND_SET_ROTATION = 3'd3;
   localparam logic [2:0] KIND_SET_LOCATION = 3'd4;

   // value slots
   localparam logic [2:0] VAL_ALPHA    = 3'd0;
   localparam logic [2:0] VAL_SCALE    = 3'd1;
   localparam logic [2:0] VAL_ROTATION = 3'd2;
   localparam logic [2:0] VAL_X        = 3'd3;
   localparam logic [2:0] VAL_Y        = 3'd4;

   // channels
   localparam logic [1:0] CH_SCALE    = 2'd1;
   localparam logic [1:0] CH_LOCATION = 2'd3;

   localparam logic signed [31:0] SCALE_RESET = 32'sh0001_0000;

   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_DECODE   = 4'd2,
      OP_DIV_STEP = 4'd3,
      OP_DIV_FIN  = 4'd4,
      OP_RATE_MUL = 4'd5,
      OP_ADVANCE  = 4'd6,
      OP_SQUARE   = 4'd7,
      OP_FACTOR   = 4'd8,
      OP_LERP_MUL = 4'd9,
      OP_LERP_WR  = 4'd10
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] ch;
      logic [2:0] vidx;
   } cmd_type;

   typedef struct packed {
      logic       is_tick;
      logic       is_set;
      logic       dur_zero;
      logic       image_on;
      logic [3:0] active;
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/tween_if.sv
// ----------------------------------------------------------------------------
// tween channel interfaces
// request, response and register-write channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface tween_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [31:0] target_value;
   logic signed [31:0] second_value;
   logic               change_x;
   logic               change_y;
   logic [15:0]        duration_ms;
   logic [15:0]        tick_ms;

   modport source (
      output valid, kind, target_value, second_value, change_x, change_y,
             duration_ms, tick_ms,
      input  ready
   );
   modport sink (
      input  valid, kind, target_value, second_value, change_x, change_y,
             duration_ms, tick_ms,
      output ready
   );
endinterface

interface tween_rsp_if;
   logic               valid;
   logic               ready;
   logic               updated;
   logic signed [31:0] alpha_now;
   logic signed [31:0] scale_now;
   logic signed [31:0] rotation_now;
   logic signed [31:0] xpos_now;
   logic signed [31:0] ypos_now;
   logic [3:0]         busy_mask;

   modport source (
      output valid, updated, alpha_now, scale_now, rotation_now, xpos_now,
             ypos_now, busy_mask,
      input  ready
   );
   modport sink (
      input  valid, updated, alpha_now, scale_now, rotation_now, xpos_now,
             ypos_now, busy_mask,
      output ready
   );
endinterface

interface tween_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tween_dp.sv
// ----------------------------------------------------------------------------
// tween_dp
// datapath: value and channel state, reciprocal divider, shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module tween_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tween_pkg::cmd_type cmd,
   input  wire logic [2:0]         kind,
   input  wire logic signed [31:0] target_value,
   input  wire logic signed [31:0] second_value,
   input  wire logic               change_x,
   input  wire logic               change_y,
   input  wire logic [15:0]        duration_ms,
   input  wire logic [15:0]        tick_ms,
   input  wire logic               csr_we,
   input  wire logic               csr_data,
   output tween_pkg::stat_type     status,
   output logic                    updated,
   output logic signed [31:0]      alpha_now,
   output logic signed [31:0]      scale_now,
   output logic signed [31:0]      rotation_now,
   output logic signed [31:0]      xpos_now,
   output logic signed [31:0]      ypos_now,
   output logic [3:0]              busy_mask
);

   localparam int PB = tween_pkg::PROGRESS_BITS;
   localparam int PW = tween_pkg::PW;
   localparam int AW = tween_pkg::MUL_A_W;
   localparam int BW = tween_pkg::MUL_B_W;
   localparam int MW = tween_pkg::MUL_P_W;
   localparam int SW = tween_pkg::SUM_W;

   // captured item
   logic [2:0]         kind_ff;
   logic signed [31:0] tv_ff, sv_ff;
   logic               cx_ff, cy_ff;
   logic [15:0]        dur_ff, ms_ff;

   logic               image_ff, image_in;
   logic               updated_ff, updated_in;

   logic signed [31:0] cur_ff   [5];
   logic signed [31:0] cur_in   [5];
   logic signed [31:0] start_ff [5];
   logic signed [31:0] start_in [5];
   logic signed [31:0] end_ff   [5];
   logic signed [31:0] end_in   [5];
   logic [PW-1:0]      rate_ff  [4];
   logic [PW-1:0]      rate_in  [4];
   logic [PW-1:0]      prog_ff  [4];
   logic [PW-1:0]      prog_in  [4];
   logic [3:0]         active_ff, active_in;

   logic [15:0]        rem_ff, rem_in;
   logic [PW-1:0]      dq_ff, dq_in;
   logic signed [MW-1:0] mul_ff, mul_in;
   logic [PW-1:0]      fac_ff, fac_in;

   logic [1:0]         set_ch;
   logic [2:0]         set_vidx;
   logic               is_set;
   logic [16:0]        div_shift, div_diff;
   logic               div_ge;
   logic signed [32:0] diff;
   logic               shrink;
   logic [PW-1:0]      sq_op, sq_fac;
   logic [SW-1:0]      psum;
   logic               pfull;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [MW-1:0] mul_p;

   assign is_set = (kind_ff == tween_pkg::KIND_SET_ALPHA)
                || (kind_ff == tween_pkg::KIND_SET_SCALE)
                || (kind_ff == tween_pkg::KIND_SET_ROTATION)
                || (kind_ff == tween_pkg::KIND_SET_LOCATION);
   assign set_ch   = 2'(kind_ff - tween_pkg::KIND_SET_ALPHA);
   // single-value channels use the value slot of the same number
   assign set_vidx = {1'b0, set_ch};

   // restoring divider step for floor(1.0 / duration)
   assign div_shift = {rem_ff, dq_ff[PW-1]};
   assign div_diff  = div_shift - {1'b0, dur_ff};
   assign div_ge    = div_shift >= {1'b0, dur_ff};

   assign diff   = {end_ff[cmd.vidx][31], end_ff[cmd.vidx]}
                 - {start_ff[cmd.vidx][31], start_ff[cmd.vidx]};
   assign shrink = start_ff[tween_pkg::VAL_SCALE] > end_ff[tween_pkg::VAL_SCALE];
   assign sq_op  = shrink ? (tween_pkg::PONE - fac_ff) : fac_ff;
   assign sq_fac = shrink ? (tween_pkg::PONE - mul_ff[PB +: PW]) : mul_ff[PB +: PW];

   assign psum  = {{(SW-PW){1'b0}}, prog_ff[cmd.ch]} + mul_ff[SW-1:0];
   assign pfull = psum >= SW'(tween_pkg::PONE);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         tween_pkg::OP_RATE_MUL: begin
            mul_a = {{(AW-16){1'b0}}, ms_ff};
            mul_b = {{(BW-PW){1'b0}}, rate_ff[cmd.ch]};
         end
         tween_pkg::OP_SQUARE: begin
            mul_a = {{(AW-PW){1'b0}}, sq_op};
            mul_b = {{(BW-PW){1'b0}}, sq_op};
         end
         tween_pkg::OP_LERP_MUL: begin
            mul_a = {{(AW-33){diff[32]}}, diff};
            mul_b = {{(BW-PW){1'b0}}, fac_ff};
         end
         default: begin
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      image_in   = csr_we ? csr_data : image_ff;
      updated_in = updated_ff;
      cur_in     = cur_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      rate_in    = rate_ff;
      prog_in    = prog_ff;
      active_in  = active_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      mul_in     = mul_ff;
      fac_in     = fac_ff;
      unique case (cmd.op)
         tween_pkg::OP_LOAD: begin
            updated_in = 1'b0;
         end
         tween_pkg::OP_DECODE: begin
            updated_in = (kind_ff == tween_pkg::KIND_TICK) && image_ff;
            rem_in     = '0;
            dq_in      = tween_pkg::PONE;
            if (kind_ff == tween_pkg::KIND_SET_LOCATION) begin
               if (dur_ff == '0) begin
                  if (cx_ff) cur_in[tween_pkg::VAL_X] = tv_ff;
                  if (cy_ff) cur_in[tween_pkg::VAL_Y] = sv_ff;
                  active_in[tween_pkg::CH_LOCATION] = 1'b0;
               end else begin
                  start_in[tween_pkg::VAL_X] = cur_ff[tween_pkg::VAL_X];
                  start_in[tween_pkg::VAL_Y] = cur_ff[tween_pkg::VAL_Y];
                  end_in[tween_pkg::VAL_X] = cx_ff ? tv_ff : cur_ff[tween_pkg::VAL_X];
                  end_in[tween_pkg::VAL_Y] = cy_ff ? sv_ff : cur_ff[tween_pkg::VAL_Y];
                  active_in[tween_pkg::CH_LOCATION] = 1'b1;
                  prog_in[tween_pkg::CH_LOCATION]   = '0;
               end
            end else if (is_set) begin
               if (dur_ff == '0) begin
                  cur_in[set_vidx]  = tv_ff;
                  active_in[set_ch] = 1'b0;
               end else begin
                  start_in[set_vidx] = cur_ff[set_vidx];
                  end_in[set_vidx]   = tv_ff;
                  active_in[set_ch]  = 1'b1;
                  prog_in[set_ch]    = '0;
               end
            end
         end
         tween_pkg::OP_DIV_STEP: begin
            rem_in = div_ge ? div_diff[15:0] : div_shift[15:0];
            dq_in  = {dq_ff[PW-2:0], div_ge};
         end
         tween_pkg::OP_DIV_FIN: begin
            rate_in[set_ch] = dq_ff;
         end
         tween_pkg::OP_RATE_MUL, tween_pkg::OP_SQUARE, tween_pkg::OP_LERP_MUL: begin
            mul_in = mul_p;
         end
         tween_pkg::OP_ADVANCE: begin
            // saturate at 1.0 and retire the channel
            if (pfull) begin
               prog_in[cmd.ch]   = tween_pkg::PONE;
               fac_in            = tween_pkg::PONE;
               active_in[cmd.ch] = 1'b0;
            end else begin
               prog_in[cmd.ch] = psum[PW-1:0];
               fac_in          = psum[PW-1:0];
            end
         end
         tween_pkg::OP_FACTOR: begin
            fac_in = sq_fac;
         end
         tween_pkg::OP_LERP_WR: begin
            // arithmetic shift of the product is the floor
            cur_in[cmd.vidx] = start_ff[cmd.vidx] + mul_ff[PB +: 32];
         end
         tween_pkg::OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff   <= 1'b1;
         updated_ff <= 1'b0;
         active_ff  <= '0;
         cur_ff[tween_pkg::VAL_ALPHA]    <= '0;
         cur_ff[tween_pkg::VAL_SCALE]    <= tween_pkg::SCALE_RESET;
         cur_ff[tween_pkg::VAL_ROTATION] <= '0;
         cur_ff[tween_pkg::VAL_X]        <= '0;
         cur_ff[tween_pkg::VAL_Y]        <= '0;
      end else begin
         image_ff   <= image_in;
         updated_ff <= updated_in;
         active_ff  <= active_in;
         cur_ff     <= cur_in;
      end
   end

   // payload, no reset needed: only read after it has been written
   always_ff @(posedge clock) begin
      if (cmd.op == tween_pkg::OP_LOAD) begin
         kind_ff <= kind;
         tv_ff   <= target_value;
         sv_ff   <= second_value;
         cx_ff   <= change_x;
         cy_ff   <= change_y;
         dur_ff  <= duration_ms;
         ms_ff   <= tick_ms;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
      rate_ff  <= rate_in;
      prog_ff  <= prog_in;
      rem_ff   <= rem_in;
      dq_ff    <= dq_in;
      mul_ff   <= mul_in;
      fac_ff   <= fac_in;
   end

   assign status.is_tick  = kind_ff == tween_pkg::KIND_TICK;
   assign status.is_set   = is_set;
   assign status.dur_zero = dur_ff == '0;
   assign status.image_on = image_ff;
   assign status.active   = active_ff;

   assign updated      = updated_ff;
   assign alpha_now    = cur_ff[tween_pkg::VAL_ALPHA];
   assign scale_now    = cur_ff[tween_pkg::VAL_SCALE];
   assign rotation_now = cur_ff[tween_pkg::VAL_ROTATION];
   assign xpos_now     = cur_ff[tween_pkg::VAL_X];
   assign ypos_now     = cur_ff[tween_pkg::VAL_Y];
   assign busy_mask    = active_ff;

endmodule

`default_nettype wire

FILE: rtl/tween_ctrl.sv
// ----------------------------------------------------------------------------
// tween_ctrl
// sequencer: decode, divider iterations and the per-channel tick walk
// ----------------------------------------------------------------------------
`default_nettype none

module tween_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire tween_pkg::stat_type status,
   output tween_pkg::cmd_type       cmd
);

   localparam int CW = tween_pkg::CNT_W;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_DECODE   = 12'b0000_0000_0010,
      ST_DIV      = 12'b0000_0000_0100,
      ST_DIV_FIN  = 12'b0000_0000_1000,
      ST_CHECK    = 12'b0000_0001_0000,
      ST_RATE_MUL = 12'b0000_0010_0000,
      ST_ADVANCE  = 12'b0000_0100_0000,
      ST_SQUARE   = 12'b0000_1000_0000,
      ST_FACTOR   = 12'b0001_0000_0000,
      ST_LERP_MUL = 12'b0010_0000_0000,
      ST_LERP_WR  = 12'b0100_0000_0000,
      ST_RESP     = 12'b1000_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [1:0]     ch_ff, ch_in;
   logic [2:0]     vidx_ff, vidx_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   tween_pkg::op_type op;

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      vidx_in   = vidx_ff;
      cnt_in    = cnt_ff;
      op        = tween_pkg::OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = tween_pkg::OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            op = tween_pkg::OP_DECODE;
            if (status.is_tick && status.image_on) begin
               ch_in    = '0;
               state_in = ST_CHECK;
            end else if (status.is_set && !status.dur_zero) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            op     = tween_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(tween_pkg::PROGRESS_BITS)) state_in = ST_DIV_FIN;
         end
         ST_DIV_FIN: begin
            op       = tween_pkg::OP_DIV_FIN;
            state_in = ST_RESP;
         end
         ST_CHECK: begin
            if (status.active[ch_ff]) begin
               vidx_in  = {1'b0, ch_ff};
               state_in = ST_RATE_MUL;
            end else if (ch_ff == tween_pkg::CH_LOCATION) begin
               state_in = ST_RESP;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_RATE_MUL: begin
            op       = tween_pkg::OP_RATE_MUL;
            state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            op       = tween_pkg::OP_ADVANCE;
            state_in = (ch_ff == tween_pkg::CH_SCALE) ? ST_SQUARE : ST_LERP_MUL;
         end
         ST_SQUARE: begin
            op       = tween_pkg::OP_SQUARE;
            state_in = ST_FACTOR;
         end
         ST_FACTOR: begin
            op       = tween_pkg::OP_FACTOR;
            state_in = ST_LERP_MUL;
         end
         ST_LERP_MUL: begin
            op       = tween_pkg::OP_LERP_MUL;
            state_in = ST_LERP_WR;
         end
         ST_LERP_WR: begin
            op = tween_pkg::OP_LERP_WR;
            // location drives x then y
            if (vidx_ff == tween_pkg::VAL_X) begin
               vidx_in  = tween_pkg::VAL_Y;
               state_in = ST_LERP_MUL;
            end else if (ch_ff == tween_pkg::CH_LOCATION) begin
               state_in = ST_RESP;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
         vidx_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         vidx_ff  <= vidx_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign cmd.op   = op;
   assign cmd.ch   = ch_ff;
   assign cmd.vidx = vidx_ff;

endmodule

`default_nettype wire

FILE: rtl/four_channel_tween_engine_top.sv
// ----------------------------------------------------------------------------
// four_channel_tween_engine_top
// animates alpha, scale, rotation and x/y location over four channels
// ----------------------------------------------------------------------------
// One item is worked on at a time and answered with exactly one response.
// A set item with zero duration, an unknown kind or a tick with no image
// goes from decode straight to the response; a timed set first runs a
// restoring divider, one quotient bit per cycle, to get the channel rate.
// A tick walks the four channels through one shared multiplier: an idle
// channel is only checked, scale adds squaring for the ease curve and
// location blends x and then y. The response stays valid until it is
// taken, and the next request can be taken in the cycle after that. The
// register port accepts a write every cycle and should only be used while
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_tween_engine_top (
   input  wire logic clock,
   input  wire logic reset,
   tween_req_if.sink   req_ch,
   tween_rsp_if.source rsp_ch,
   tween_csr_if.sink   csr_ch
);

   tween_pkg::cmd_type  cmd;
   tween_pkg::stat_type status;

   // register write channel never stalls
   assign csr_ch.ready = 1'b1;

   // sequencer: owns both handshakes and issues one command per cycle
   tween_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: captures the item on its transfer, holds all channel state;
   // the response payload is read straight from the value registers,
   // which stay still while the response waits
   tween_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .kind         (req_ch.kind),
      .target_value (req_ch.target_value),
      .second_value (req_ch.second_value),
      .change_x     (req_ch.change_x),
      .change_y     (req_ch.change_y),
      .duration_ms  (req_ch.duration_ms),
      .tick_ms      (req_ch.tick_ms),
      .csr_we       (csr_ch.valid),
      .csr_data     (csr_ch.data),
      .status       (status),
      .updated      (rsp_ch.updated),
      .alpha_now    (rsp_ch.alpha_now),
      .scale_now    (rsp_ch.scale_now),
      .rotation_now (rsp_ch.rotation_now),
      .xpos_now     (rsp_ch.xpos_now),
      .ypos_now     (rsp_ch.ypos_now),
      .busy_mask    (rsp_ch.busy_mask)
   );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the four-channel tween engine: a scripted opening
// walks resets, jumps, extremes and the odd kinds, then random phases drive
// set and tick traffic under random back-pressure, checked by a model here
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tween_pkg::*;

   typedef longint unsigned u64_t;

   // channels the package does not name
   localparam logic [1:0] CH_ALPHA    = 2'd0;
   localparam logic [1:0] CH_ROTATION = 2'd2;

   // kinds with no meaning, the block must leave its state alone
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   // progress of 1.0
   localparam u64_t UNITY = u64_t'(1) << PROGRESS_BITS;

   // script rows that leave the image register alone
   localparam int NO_WR = -1;

   // random phases: image register setting and number of meaningful items
   localparam bit PHASE_IMAGE [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam int PHASE_ITEMS [6] = '{130, 130, 40, 130, 40, 130};

   // settle time after the last response, longer than any item
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      logic [2:0]         kind;
      logic signed [31:0] tv;
      logic signed [31:0] sv;
      logic               cx;
      logic               cy;
      logic [15:0]        dur;
      logic [15:0]        ms;
   } tween_item_t;

   typedef struct {
      logic        updated;
      logic [31:0] alpha;
      logic [31:0] scale;
      logic [31:0] rotation;
      logic [31:0] xpos;
      logic [31:0] ypos;
      logic [3:0]  busy;
   } tween_frame_t;

   // one scripted item; the w_ fields hold a hand-written expectation when
   // typed is set, otherwise the model's answer is used
   typedef struct {
      logic [2:0]  kind;
      logic [31:0] tv;
      logic [31:0] sv;
      logic        cx;
      logic        cy;
      logic [15:0] dur;
      logic [15:0] ms;
      int          img_wr;
      bit          typed;
      logic        w_upd;
      logic [31:0] w_alpha;
      logic [31:0] w_scale;
      logic [31:0] w_rot;
      logic [31:0] w_x;
      logic [31:0] w_y;
      logic [3:0]  w_busy;
   } script_row_t;

   logic clock;
   logic reset;

   tween_req_if req_bus ();
   tween_rsp_if rsp_bus ();
   tween_csr_if csr_bus ();

   four_channel_tween_engine_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // ------------------------------------------------------------------------
   // model state: display values, transition end points, per-channel rate,
   // progress and busy flag, and the image register
   // ------------------------------------------------------------------------
   longint cur_val [5];
   longint from_val [5];
   longint to_val [5];
   u64_t   ch_rate [4];
   u64_t   ch_prog [4];
   bit     ch_busy [4];
   bit     image_on;

   tween_frame_t frames_due [$];   // expected responses, oldest first
   int           mismatches = 0;
   bit           calm = 1'b0;      // no gaps and no stalls while set
   int           stall_left = 0;

   // opening script: reset view, jumps to the extremes, location keep on
   // each axis, odd kinds, then timed transitions in both directions,
   // a zero tick, a jump over a running scale, and a tick with no image
   script_row_t script_rows [25] = '{
      // tick of 0 ms right after reset
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'd0, NO_WR,
        1'b1, 1'b1, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 4'h0},
      // alpha jumps to the top
      '{KIND_SET_ALPHA, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 16'd0, 16'hFFFF,
        NO_WR, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
        4'h0},
      // rotation jumps to the bottom
      '{KIND_SET_ROTATION, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0,
        16'd7, NO_WR, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0001_0000,
        32'h8000_0000, 32'h0, 32'h0, 4'h0},
      // location jumps on both axes
      '{KIND_SET_LOCATION, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 16'd0,
        16'd0, NO_WR, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0001_0000,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 4'h0},
      // location jump, x kept
      '{KIND_SET_LOCATION, 32'h1234_5678, 32'h0, 1'b0, 1'b1, 16'd0, 16'd0,
        NO_WR, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0, 4'h0},
      // location jump, y kept
      '{KIND_SET_LOCATION, 32'h0, 32'h5555_AAAA, 1'b1, 1'b0, 16'd0, 16'd0,
        NO_WR, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000,
        32'h0, 32'h0, 4'h0},
      // odd kinds change nothing, even with a duration
      '{KIND_SPARE_LO, 32'hDEAD_BEEF, 32'h1357_9BDF, 1'b1, 1'b1, 16'd9,
        16'd3, NO_WR, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0001_0000,
        32'h8000_0000, 32'h0, 32'h0, 4'h0},
      '{KIND_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF,
        16'hFFFF, NO_WR, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0001_0000,
        32'h8000_0000, 32'h0, 32'h0, 4'h0},
      // scale jumps to zero
      '{KIND_SET_SCALE, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'd0, NO_WR,
        1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 4'h0},
      // alpha over its full span in 1 ms, then a zero tick and a 1 ms tick
      '{KIND_SET_ALPHA, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 16'd1, 16'd0,
        NO_WR, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'd0, NO_WR,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'd1, NO_WR,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      // growing scale over the longest duration
      '{KIND_SET_SCALE, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 16'hFFFF, 16'd0,
        NO_WR, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_SET_ROTATION, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 16'd3, 16'd0,
        NO_WR, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      // timed location that keeps y
      '{KIND_SET_LOCATION, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 16'd7,
        16'd0, NO_WR, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'd1, NO_WR,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'hFFFF, NO_WR,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      // shrinking scale eases out
      '{KIND_SET_SCALE, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 16'd100, 16'd0,
        NO_WR, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      // timed location that keeps x
      '{KIND_SET_LOCATION, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1, 16'd1000,
        16'd0, NO_WR, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'd37, NO_WR,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      // jump lands over a running scale transition
      '{KIND_SET_SCALE, 32'h0001_8000, 32'h0, 1'b0, 1'b0, 16'd0, 16'd0,
        NO_WR, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'hFFFF, NO_WR,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_SET_ALPHA, 32'h0, 32'h0, 1'b0, 1'b0, 16'd500, 16'd0, NO_WR,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      // no image: the tick is dropped, then the image comes back
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'd100, 0,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0},
      '{KIND_TICK, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 16'd100, 1,
        1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0}
   };

   // ------------------------------------------------------------------------
   // model
   // ------------------------------------------------------------------------
   function automatic void reset_model();
      for (int i = 0; i < 5; i++) begin
         cur_val[i]  = 0;
         from_val[i] = 0;
         to_val[i]   = 0;
      end
      cur_val[VAL_SCALE] = longint'(SCALE_RESET);
      for (int c = 0; c < 4; c++) begin
         ch_rate[c] = 0;
         ch_prog[c] = 0;
         ch_busy[c] = 1'b0;
      end
      image_on = 1'b1;
   endfunction

   // floor(a * f / 1.0), rounding toward minus infinity
   function automatic longint frac_of(input longint a, input u64_t f);
      u64_t m;
      if (a >= 0) begin
         m = u64_t'(a) * f;
         return longint'(m >> PROGRESS_BITS);
      end
      m = u64_t'(-a) * f;
      return -longint'((m + UNITY - 1) >> PROGRESS_BITS);
   endfunction

   function automatic longint blend(input int slot, input u64_t f);
      return from_val[slot] + frac_of(to_val[slot] - from_val[slot], f);
   endfunction

   function automatic void launch(input int ch, input logic [15:0] dur);
      ch_busy[ch] = 1'b1;
      ch_rate[ch] = UNITY / u64_t'(dur);
      ch_prog[ch] = 0;
   endfunction

   // alpha, scale and rotation: the value slot equals the channel number
   function automatic void set_channel(input int ch, input longint target,
                                       input logic [15:0] dur);
      if (dur == 16'd0) begin
         cur_val[ch] = target;
         ch_busy[ch] = 1'b0;
      end else begin
         from_val[ch] = cur_val[ch];
         to_val[ch]   = target;
         launch(ch, dur);
      end
   endfunction

   function automatic void set_place(input tween_item_t it);
      if (it.dur == 16'd0) begin
         if (it.cx) cur_val[VAL_X] = longint'(it.tv);
         if (it.cy) cur_val[VAL_Y] = longint'(it.sv);
         ch_busy[CH_LOCATION] = 1'b0;
      end else begin
         from_val[VAL_X] = cur_val[VAL_X];
         from_val[VAL_Y] = cur_val[VAL_Y];
         to_val[VAL_X]   = it.cx ? longint'(it.tv) : cur_val[VAL_X];
         to_val[VAL_Y]   = it.cy ? longint'(it.sv) : cur_val[VAL_Y];
         launch(CH_LOCATION, it.dur);
      end
   endfunction

   function automatic void run_tick(input logic [15:0] ms);
      u64_t p;
      u64_t q;
      u64_t f;
      for (int ch = 0; ch < 4; ch++) begin
         if (ch_busy[ch]) begin
            p = ch_prog[ch] + ch_rate[ch] * u64_t'(ms);
            if (p >= UNITY) begin
               p = UNITY;
               ch_busy[ch] = 1'b0;
            end
            ch_prog[ch] = p;
            if (ch == CH_SCALE) begin
               // ease in while growing, ease out while shrinking
               if (from_val[VAL_SCALE] > to_val[VAL_SCALE]) begin
                  q = UNITY - p;
                  f = UNITY - ((q * q) >> PROGRESS_BITS);
               end else begin
                  f = (p * p) >> PROGRESS_BITS;
               end
               cur_val[VAL_SCALE] = blend(VAL_SCALE, f);
            end else if (ch == CH_LOCATION) begin
               cur_val[VAL_X] = blend(VAL_X, p);
               cur_val[VAL_Y] = blend(VAL_Y, p);
            end else begin
               cur_val[ch] = blend(ch, p);
            end
         end
      end
   endfunction

   // applies one accepted item and returns the display frame it produces
   function automatic tween_frame_t apply_item(input tween_item_t it);
      tween_frame_t fr;
      fr.updated = 1'b0;
      case (it.kind)
         KIND_TICK: begin
            if (image_on) begin
               run_tick(it.ms);
               fr.updated = 1'b1;
            end
         end
         KIND_SET_ALPHA:    set_channel(CH_ALPHA, longint'(it.tv), it.dur);
         KIND_SET_SCALE:    set_channel(CH_SCALE, longint'(it.tv), it.dur);
         KIND_SET_ROTATION: set_channel(CH_ROTATION, longint'(it.tv), it.dur);
         KIND_SET_LOCATION: set_place(it);
         default: ;
      endcase
      fr.alpha    = cur_val[VAL_ALPHA][31:0];
      fr.scale    = cur_val[VAL_SCALE][31:0];
      fr.rotation = cur_val[VAL_ROTATION][31:0];
      fr.xpos     = cur_val[VAL_X][31:0];
      fr.ypos     = cur_val[VAL_Y][31:0];
      for (int c = 0; c < 4; c++)
         fr.busy[c] = ch_busy[c];
      return fr;
   endfunction

   // ------------------------------------------------------------------------
   // random picks
   // ------------------------------------------------------------------------

   // mostly no gap, often a short one, now and then a long one
   function automatic int idle_cycles();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // full-range words, on-screen sized values, and the corners
   function automatic logic [31:0] pick_value();
      int r;
      logic signed [31:0] whole;
      r = $urandom_range(0, 99);
      if (r < 45) return $urandom();
      if (r < 85) begin
         whole = $signed(32'($urandom_range(0, 800))) - 32'sd400;
         return (whole <<< 16) + 32'($urandom_range(0, 65535));
      end
      case ($urandom_range(0, 3))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0;
         default: return 32'h0001_0000;
      endcase
   endfunction

   // short transitions dominate so that ticks carry them to the end
   function automatic logic [15:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 16'd0;
      if (r < 70) return 16'($urandom_range(1, 200));
      if (r < 90) return 16'($urandom());
      return r[0] ? 16'hFFFF : 16'd1;
   endfunction

   function automatic logic [15:0] pick_tick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 16'($urandom_range(0, 40));
      if (r < 80) return 16'($urandom_range(0, 1000));
      if (r < 95) return 16'($urandom());
      return r[0] ? 16'hFFFF : 16'd0;
   endfunction

   function automatic tween_item_t random_item();
      tween_item_t it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         it.kind = KIND_TICK;
      else if (r < 95)
         it.kind = 3'($urandom_range(KIND_SET_ALPHA, KIND_SET_LOCATION));
      else
         it.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      it.tv  = pick_value();
      it.sv  = pick_value();
      it.cx  = 1'($urandom_range(0, 1));
      it.cy  = 1'($urandom_range(0, 1));
      it.dur = pick_duration();
      it.ms  = pick_tick();
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // clock and limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // far beyond the slowest legal run of about 2 ms
   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // driving side; every task starts and ends on a falling edge
   // ------------------------------------------------------------------------

   // one request transfer; the expectation is queued at the accepting edge
   task automatic send_item(input tween_item_t it, input bit typed,
                            input tween_frame_t want);
      tween_frame_t due;
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= it.kind;
      req_bus.target_value <= it.tv;
      req_bus.second_value <= it.sv;
      req_bus.change_x     <= it.cx;
      req_bus.change_y     <= it.cy;
      req_bus.duration_ms  <= it.dur;
      req_bus.tick_ms      <= it.ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // model always advances; a hand-written row overrides its answer
      due = apply_item(it);
      frames_due.push_back(typed ? want : due);
      @(negedge clock);
   endtask

   // sender holds off until every expected response has been taken
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
   endtask

   // register write, only called with the block idle
   task automatic write_image(input bit on);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= on;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      image_on = on;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // response side: random stalls on ready, checks at the rising edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (calm) begin
         rsp_bus.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = idle_cycles();
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      tween_frame_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frames_due.size() == 0) begin
            $display("%0t: response transfer with nothing expected", $time);
            mismatches++;
         end else begin
            want = frames_due.pop_front();
            check_field("updated", 32'(want.updated), 32'(rsp_bus.updated));
            check_field("alpha_now", want.alpha, rsp_bus.alpha_now);
            check_field("scale_now", want.scale, rsp_bus.scale_now);
            check_field("rotation_now", want.rotation, rsp_bus.rotation_now);
            check_field("xpos_now", want.xpos, rsp_bus.xpos_now);
            check_field("ypos_now", want.ypos, rsp_bus.ypos_now);
            check_field("busy_mask", 32'(want.busy), 32'(rsp_bus.busy_mask));
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      tween_item_t  it;
      tween_frame_t want;
      script_row_t  row;
      int           done;

      // every input known from time zero
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_TICK;
      req_bus.target_value = '0;
      req_bus.second_value = '0;
      req_bus.change_x     = 1'b0;
      req_bus.change_y     = 1'b0;
      req_bus.duration_ms  = '0;
      req_bus.tick_ms      = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = 1'b0;
      reset_model();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register starts written even though its reset value matches
      write_image(1'b1);

      // scripted opening; register writes wait for the block to go idle
      foreach (script_rows[i]) begin
         row = script_rows[i];
         if (row.img_wr != NO_WR) begin
            wait_drained();
            write_image(row.img_wr[0]);
         end
         it.kind = row.kind;
         it.tv   = row.tv;
         it.sv   = row.sv;
         it.cx   = row.cx;
         it.cy   = row.cy;
         it.dur  = row.dur;
         it.ms   = row.ms;
         want.updated  = row.w_upd;
         want.alpha    = row.w_alpha;
         want.scale    = row.w_scale;
         want.rotation = row.w_rot;
         want.xpos     = row.w_x;
         want.ypos     = row.w_y;
         want.busy     = row.w_busy;
         send_item(it, row.typed, want);
      end

      // random phases, each opened on an idle block with a register write;
      // the second phase runs with no gaps and no stalls at all
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         calm = (ph == 1);
         write_image(PHASE_IMAGE[ph]);
         done = 0;
         while (done < PHASE_ITEMS[ph]) begin
            // now and then let everything drain mid-phase
            if ($urandom_range(0, 99) == 0) wait_drained();
            it = random_item();
            // odd kinds are noise and do not count
            if (it.kind <= KIND_SET_LOCATION) done++;
            send_item(it, 1'b0, want);
         end
      end

      calm = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: four_channel_tween_engine_top.f
rtl/tween_pkg.sv
rtl/tween_if.sv
rtl/tween_dp.sv
rtl/tween_ctrl.sv
rtl/four_channel_tween_engine_top.sv
dv/tb.sv
